// ===== rtl/ieh_pkg.sv =====
// Package for the IPv4 / Ethernet header generator.
// Holds header constants, register indexes and the shared types; no dependencies.
package ieh_pkg;

    localparam int HDR_BYTES   = 34;
    localparam int IDX_W       = 6;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 48;
    localparam int TOTAL_W     = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_BYTES - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_HOP_MAC = CFG_IDX_W'(2);

    // Fixed header fields
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_TOS        = 8'h00;
    localparam logic [15:0] IP_FRAG       = 16'h0000;
    localparam logic [7:0]  IP_TTL        = 8'd64;
    localparam logic [TOTAL_W-1:0] IP_HDR_LEN = TOTAL_W'(20);
    localparam logic [15:0] IDENT_RESET   = 16'd1;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [47:0] source_mac;
        logic [47:0] next_hop_mac;
    } t_cfg;

    // One classified request on its way to the serializer
    typedef struct packed {
        logic [31:0]        dest_ip;
        logic [7:0]         protocol;
        logic [TOTAL_W-1:0] ip_len;
        logic [15:0]        ident;
        logic [15:0]        csum;
    } t_hdr_desc;

endpackage

// ===== rtl/ipv4_ethernet_header_generator.sv =====
// Top level of the IPv4 / Ethernet header generator.
// Depends on ieh_pkg, ieh_front, ieh_queue and ieh_back.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries one send request per beat:
//   destination IP, protocol and payload length. Result channel (o_out_valid /
//   i_out_stall) returns the 34-byte Ethernet II + IPv4 header, one byte per beat,
//   in wire order, with its byte index and o_last on byte 33.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   register 0 source IP, 1 own MAC, 2 next-hop MAC; other indexes are dropped.
//   Write configuration only while no request is in flight.
// Timing:
//   The first header byte passes two front stages (capture, partial checksum sums),
//   the queue, then the output register. A request occupies the serializer for all
//   34 of its bytes, one byte per cycle through the single output register while
//   the output does not stall; requests of the next header are taken while the
//   current one still streams.
// Reset:
//   Synchronous, active low. Clears all valids and the queue, zeroes the
//   configuration registers and sets the identification counter to 1.
// Stall:
//   A stalled output byte holds; the serializer, then the queue, then the front
//   stages back up, and o_in_stall rises once the front is full.
module ipv4_ethernet_header_generator #(
    parameter int QUEUE_DEPTH = ieh_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [31:0]                       i_dest_ip,
    input  logic [7:0]                        i_protocol,
    input  logic [10:0]                       i_body_len,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_header_byte,
    output logic [ieh_pkg::IDX_W-1:0]         o_byte_index,
    output logic                              o_last,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ieh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ieh_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ieh_pkg::*;

    t_cfg      r_cfg;
    t_hdr_desc w_push_desc, w_head;
    logic      w_push, w_q_ready, w_pop, w_q_nonempty;

    assign o_cfg_ready = 1'b1;

    // Register file: take a write on every beat, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SOURCE_IP:    r_cfg.source_ip    <= i_cfg_data[31:0];
                REG_SOURCE_MAC:   r_cfg.source_mac   <= i_cfg_data[47:0];
                REG_NEXT_HOP_MAC: r_cfg.next_hop_mac <= i_cfg_data[47:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    ieh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_dest_ip     (i_dest_ip),
        .i_protocol    (i_protocol),
        .i_body_len    (i_body_len),
        .o_push        (w_push),
        .o_desc        (w_push_desc),
        .i_q_ready     (w_q_ready)
    );

    ieh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_desc     (w_push_desc),
        .o_ready    (w_q_ready),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_nonempty (w_q_nonempty)
    );

    ieh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (w_head),
        .i_q_nonempty  (w_q_nonempty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_header_byte (o_header_byte),
        .o_byte_index  (o_byte_index),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/ieh_front.sv =====
// Front end: accepts requests, stamps identification, computes the header checksum.
// Depends on ieh_pkg; feeds ieh_queue.
module ieh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ieh_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [31:0]       i_dest_ip,
    input  logic [7:0]        i_protocol,
    input  logic [10:0]       i_body_len,
    output logic              o_push,
    output ieh_pkg::t_hdr_desc o_desc,
    input  logic              i_q_ready
);
    import ieh_pkg::*;

    logic               r_s1_vld, r_s2_vld;
    logic [31:0]        r_s1_dst, r_s2_dst;
    logic [7:0]         r_s1_proto, r_s2_proto;
    logic [TOTAL_W-1:0] r_s1_total, r_s2_total;
    logic [15:0]        r_s1_ident, r_s2_ident;
    logic [17:0]        r_s2_sum_a, r_s2_sum_b;
    logic [15:0]        r_ident;
    logic [15:0]        n_ident;

    logic        w_s2_free, w_s1_move, w_s1_free, w_accept;
    logic [17:0] w_sum_a, w_sum_b;
    logic [18:0] w_sum;
    logic [16:0] w_fold1, w_fold2;

    assign w_s2_free  = !r_s2_vld || i_q_ready;
    assign w_s1_move  = r_s1_vld && w_s2_free;
    assign w_s1_free  = !r_s1_vld || w_s2_free;
    assign o_in_stall = !w_s1_free;
    assign w_accept   = i_in_valid && w_s1_free;
    assign n_ident    = r_ident + 16'd1;

    // Partial sums: fixed words plus length, ident, TTL/protocol; then the addresses
    assign w_sum_a = 18'({IP_VER_IHL, IP_TOS}) + 18'(r_s1_total) + 18'(r_s1_ident)
                   + 18'({IP_TTL, r_s1_proto}) + 18'(IP_FRAG);
    assign w_sum_b = 18'(i_cfg.source_ip[31:16]) + 18'(i_cfg.source_ip[15:0])
                   + 18'(r_s1_dst[31:16]) + 18'(r_s1_dst[15:0]);

    // End-around carry fold, twice covers every sum
    assign w_sum   = 19'(r_s2_sum_a) + 19'(r_s2_sum_b);
    assign w_fold1 = 17'(w_sum[15:0]) + 17'(w_sum[18:16]);
    assign w_fold2 = 17'(w_fold1[15:0]) + 17'(w_fold1[16]);

    assign o_push           = r_s2_vld && i_q_ready;
    assign o_desc.dest_ip   = r_s2_dst;
    assign o_desc.protocol  = r_s2_proto;
    assign o_desc.ip_len    = r_s2_total;
    assign o_desc.ident     = r_s2_ident;
    assign o_desc.csum      = ~w_fold2[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_ident  <= IDENT_RESET;
        end else begin
            if (w_s1_free) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_accept) begin
                r_ident <= n_ident;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_dst   <= i_dest_ip;
            r_s1_proto <= i_protocol;
            r_s1_total <= IP_HDR_LEN + TOTAL_W'(i_body_len);
            r_s1_ident <= r_ident;
        end
        if (w_s1_move) begin
            r_s2_dst   <= r_s1_dst;
            r_s2_proto <= r_s1_proto;
            r_s2_total <= r_s1_total;
            r_s2_ident <= r_s1_ident;
            r_s2_sum_a <= w_sum_a;
            r_s2_sum_b <= w_sum_b;
        end
    end

endmodule

// ===== rtl/ieh_queue.sv =====
// Short descriptor queue between front end and serializer.
// Depends on ieh_pkg for the descriptor type.
module ieh_queue #(
    parameter int DEPTH = ieh_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ieh_pkg::t_hdr_desc i_desc,
    output logic               o_ready,
    input  logic               i_pop,
    output ieh_pkg::t_hdr_desc o_head,
    output logic               o_nonempty
);
    import ieh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_hdr_desc        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready    = (r_count != CNT_FULL);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== rtl/ieh_back.sv =====
// Serializer: walks the 34 header bytes of the head descriptor into the output register.
// Depends on ieh_pkg; reads from ieh_queue.
module ieh_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ieh_pkg::t_cfg      i_cfg,
    input  ieh_pkg::t_hdr_desc i_head,
    input  logic               i_q_nonempty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_header_byte,
    output logic [ieh_pkg::IDX_W-1:0] o_byte_index,
    output logic               o_last
);
    import ieh_pkg::*;

    localparam int HDR_W = HDR_BYTES * 8;

    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_last;
    logic [IDX_W-1:0] r_idx;

    logic             w_out_free, w_load, w_at_last;
    logic [IDX_W-1:0] w_rev;
    logic [HDR_W-1:0] w_hdr;

    // Wire order, byte 0 in the top bits
    assign w_hdr = {i_cfg.next_hop_mac, i_cfg.source_mac, ETH_TYPE_IPV4,
                    IP_VER_IHL, IP_TOS, 16'(i_head.ip_len), i_head.ident,
                    IP_FRAG, IP_TTL, i_head.protocol, i_head.csum,
                    i_cfg.source_ip, i_head.dest_ip};

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_load     = w_out_free && i_q_nonempty;
    assign w_at_last  = (r_idx == LAST_IDX);
    assign w_rev      = LAST_IDX - r_idx;
    assign o_pop      = w_load && w_at_last;

    assign o_out_valid   = r_out_vld;
    assign o_header_byte = r_out_byte;
    assign o_byte_index  = r_out_idx;
    assign o_last        = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (w_out_free) begin
                r_out_vld <= i_q_nonempty;
            end
            if (w_load) begin
                r_idx <= w_at_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= w_hdr[{w_rev, 3'b000} +: 8];
            r_out_idx  <= r_idx;
            r_out_last <= w_at_last;
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_idx <= LAST_IDX))
        else $error("byte index beyond header");
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_last == (r_out_idx == LAST_IDX)))
        else $error("last flag not on final byte");
    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_vld && r_out_last && r_idx == '0))
        else $error("descriptor released before its final byte");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_at_last) |=> (r_out_idx == $past(r_idx) && r_idx == $past(r_idx) + 6'd1))
        else $error("byte counter skipped");
`endif

endmodule
